@@ sv/tcc_pkg.sv @@
`timescale 1ns / 1ps
// Touch coordinate calibrator: shared constants, types and datapath functions.
// No dependencies; used by every other file of the block.
package tcc_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 320;

    localparam int RAW_W   = 12;
    localparam int X_W     = 8;
    localparam int Y_W     = 9;
    localparam int POINT_W = 24;
    localparam int DATA_W  = 32;

    localparam int NUM_REGS  = 5;
    localparam int ADDR_W    = $clog2(NUM_REGS * 4);
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_POINT0 = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_POINT1 = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_POINT2 = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_POINT3 = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_ENABLE = REG_IDX_W'(4);

    localparam logic [RAW_W-1:0] DEF_X_LO = RAW_W'(300);
    localparam logic [RAW_W-1:0] DEF_X_HI = RAW_W'(3800);
    localparam logic [RAW_W-1:0] DEF_Y_LO = RAW_W'(210);
    localparam logic [RAW_W-1:0] DEF_Y_HI = RAW_W'(3700);

    localparam int MAX_SIZE = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
    localparam int QW       = $clog2(MAX_SIZE);
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = (QW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QP       = DIV_STAGES * DIV_STEPS;
    localparam int N_W      = RAW_W + QP;

    localparam logic [X_W-1:0] X_MAX_CODE = X_W'(SCREEN_WIDTH - 1);
    localparam logic [Y_W-1:0] Y_MAX_CODE = Y_W'(SCREEN_HEIGHT - 1);

    typedef enum logic [1:0] {
        SEL_QUOT,
        SEL_ZERO,
        SEL_MAX
    } res_sel_t;

    typedef struct packed {
        logic [RAW_W-1:0] x_lo;
        logic [RAW_W-1:0] x_hi;
        logic [RAW_W-1:0] y_lo;
        logic [RAW_W-1:0] y_hi;
        logic             enable;
    } cal_t;

    typedef struct packed {
        res_sel_t         sel;
        logic [RAW_W-1:0] rem;
        logic [RAW_W-1:0] dvs;
        logic [QP-1:0]    low;
        logic [QP-1:0]    quo;
    } axis_t;

    typedef struct packed {
        axis_t x;
        axis_t y;
        logic  err;
    } item_t;

    // |raw-lo| * size over |hi-lo|; sign and overflow resolved up front
    function automatic axis_t axis_prep(input logic [RAW_W-1:0] raw,
                                        input logic [RAW_W-1:0] lo,
                                        input logic [RAW_W-1:0] hi,
                                        input logic [SIZE_W-1:0] size);
        logic signed [RAW_W:0] diff;
        logic signed [RAW_W:0] den;
        logic [RAW_W-1:0]      a;
        logic [RAW_W-1:0]      d;
        logic [N_W-1:0]        n;
        axis_t                 o;
        diff = $signed({1'b0, raw}) - $signed({1'b0, lo});
        den  = $signed({1'b0, hi}) - $signed({1'b0, lo});
        a    = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
        d    = den[RAW_W] ? RAW_W'(-den) : den[RAW_W-1:0];
        n    = N_W'(a) * N_W'(size);
        o.rem = n[N_W-1 -: RAW_W];
        o.low = n[QP-1:0];
        o.dvs = d;
        o.quo = '0;
        if (d == '0)
            o.sel = SEL_ZERO;
        else if (diff[RAW_W] ^ den[RAW_W])
            o.sel = SEL_ZERO;
        else if (a >= d)
            o.sel = SEL_MAX;
        else
            o.sel = SEL_QUOT;
        return o;
    endfunction

    // one restoring division step
    function automatic axis_t axis_step(input axis_t s);
        logic [RAW_W:0] t;
        axis_t          o;
        o   = s;
        t   = {s.rem, s.low[QP-1]};
        o.low = {s.low[QP-2:0], 1'b0};
        if (t >= {1'b0, s.dvs})
        begin
            o.rem = RAW_W'(t - {1'b0, s.dvs});
            o.quo = {s.quo[QP-2:0], 1'b1};
        end
        else
        begin
            o.rem = t[RAW_W-1:0];
            o.quo = {s.quo[QP-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

@@ sv/tcc_cfg.sv @@
`timescale 1ns / 1ps
// Calibration register file with APB-style access; derives the averaged edges.
// Depends on tcc_pkg.
module tcc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::ADDR_W-1:0]    paddr,
    input  logic [tcc_pkg::DATA_W-1:0]    pwdata,
    output logic [tcc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    output tcc_pkg::cal_t                 cal
);

    logic [tcc_pkg::POINT_W-1:0]   point0_reg;
    logic [tcc_pkg::POINT_W-1:0]   point1_reg;
    logic [tcc_pkg::POINT_W-1:0]   point2_reg;
    logic [tcc_pkg::POINT_W-1:0]   point3_reg;
    logic                          enable_reg;
    logic [tcc_pkg::REG_IDX_W-1:0] idx;
    logic                          wr;
    logic [tcc_pkg::RAW_W:0]       sum_x1;
    logic [tcc_pkg::RAW_W:0]       sum_x2;
    logic [tcc_pkg::RAW_W:0]       sum_y1;
    logic [tcc_pkg::RAW_W:0]       sum_y2;

    assign pready = 1'b1;
    assign idx    = paddr[tcc_pkg::ADDR_W-1:2];
    assign wr     = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point0_reg <= '0;
            point1_reg <= '0;
            point2_reg <= '0;
            point3_reg <= '0;
            enable_reg <= 1'b0;
        end
        else if (wr)
        begin
            case (idx)
                tcc_pkg::REG_POINT0: point0_reg <= pwdata[tcc_pkg::POINT_W-1:0];
                tcc_pkg::REG_POINT1: point1_reg <= pwdata[tcc_pkg::POINT_W-1:0];
                tcc_pkg::REG_POINT2: point2_reg <= pwdata[tcc_pkg::POINT_W-1:0];
                tcc_pkg::REG_POINT3: point3_reg <= pwdata[tcc_pkg::POINT_W-1:0];
                tcc_pkg::REG_ENABLE: enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tcc_pkg::REG_POINT0: prdata = tcc_pkg::DATA_W'(point0_reg);
            tcc_pkg::REG_POINT1: prdata = tcc_pkg::DATA_W'(point1_reg);
            tcc_pkg::REG_POINT2: prdata = tcc_pkg::DATA_W'(point2_reg);
            tcc_pkg::REG_POINT3: prdata = tcc_pkg::DATA_W'(point3_reg);
            tcc_pkg::REG_ENABLE: prdata = tcc_pkg::DATA_W'(enable_reg);
            default:             prdata = '0;
        endcase
    end

    // x in bits 11:0, y in bits 23:12
    assign sum_x1 = {1'b0, point0_reg[11:0]}  + {1'b0, point3_reg[11:0]};
    assign sum_x2 = {1'b0, point1_reg[11:0]}  + {1'b0, point2_reg[11:0]};
    assign sum_y1 = {1'b0, point0_reg[23:12]} + {1'b0, point1_reg[23:12]};
    assign sum_y2 = {1'b0, point2_reg[23:12]} + {1'b0, point3_reg[23:12]};

    assign cal.x_lo   = sum_x1[tcc_pkg::RAW_W:1];
    assign cal.x_hi   = sum_x2[tcc_pkg::RAW_W:1];
    assign cal.y_lo   = sum_y1[tcc_pkg::RAW_W:1];
    assign cal.y_hi   = sum_y2[tcc_pkg::RAW_W:1];
    assign cal.enable = enable_reg;

endmodule

@@ sv/tcc_div_stage.sv @@
`timescale 1ns / 1ps
// One registered divider stage: a few restoring steps on both axes.
// Depends on tcc_pkg.
module tcc_div_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  tcc_pkg::item_t  in_item,
    output logic            in_rdy,
    output logic            out_valid,
    output tcc_pkg::item_t  out_item,
    input  logic            out_rdy
);

    logic           valid_reg;
    tcc_pkg::item_t item_reg;
    tcc_pkg::item_t item_next;

    assign in_rdy = !valid_reg || out_rdy;

    always_comb
    begin
        item_next = in_item;
        for (int s = 0; s < tcc_pkg::DIV_STEPS; s++)
        begin
            item_next.x = tcc_pkg::axis_step(item_next.x);
            item_next.y = tcc_pkg::axis_step(item_next.y);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_rdy)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_rdy && in_valid)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // partial x remainder never reaches the divisor on items that take the quotient
    a_rem_x: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && item_reg.x.sel == tcc_pkg::SEL_QUOT |-> item_reg.x.rem < item_reg.x.dvs)
        else $error("x remainder not below divisor");

endmodule

@@ sv/touch_coordinate_calibrator_unit.sv @@
`timescale 1ns / 1ps
// Top level of the touch coordinate calibrator: config, prep stage, divider, clamp.
// Depends on tcc_pkg, tcc_cfg and tcc_div_stage.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  sample   | sample_valid / sample_stall| raw_x, raw_y
//  point    | point_valid / point_stall  | screen_x, screen_y, span_error
//  config   | psel, penable, pready      | paddr, pwdata, prdata
//
// One sample per cycle while point is not stalled; the path runs through
// the prep register, the divider stages of three restoring steps and the output register.
// Reset clears valid bits and calibration registers; payload is not reset.
// A stall on point holds every full stage behind it; bubbles are squeezed out.
module touch_coordinate_calibrator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tcc_pkg::DATA_W-1:0]  pwdata,
    output logic [tcc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        sample_valid,
    output logic                        sample_stall,
    input  logic [tcc_pkg::RAW_W-1:0]   raw_x,
    input  logic [tcc_pkg::RAW_W-1:0]   raw_y,
    output logic                        point_valid,
    input  logic                        point_stall,
    output logic [tcc_pkg::X_W-1:0]     screen_x,
    output logic [tcc_pkg::Y_W-1:0]     screen_y,
    output logic                        span_error
);

    localparam int  NS    = tcc_pkg::DIV_STAGES;
    localparam bit  X_CHK = tcc_pkg::SCREEN_WIDTH  <= (2 ** tcc_pkg::X_W);
    localparam bit  Y_CHK = tcc_pkg::SCREEN_HEIGHT <= (2 ** tcc_pkg::Y_W);

    tcc_pkg::cal_t            cal;
    logic                     lvl_valid [NS+1];
    tcc_pkg::item_t           lvl_item  [NS+1];
    logic                     lvl_rdy   [NS+1];

    logic                     prep_valid_reg;
    tcc_pkg::item_t           prep_item_reg;
    tcc_pkg::item_t           prep_item_next;
    logic [tcc_pkg::RAW_W-1:0] x_lo;
    logic [tcc_pkg::RAW_W-1:0] x_hi;
    logic [tcc_pkg::RAW_W-1:0] y_lo;
    logic [tcc_pkg::RAW_W-1:0] y_hi;
    logic                     prep_rdy;

    logic                     point_valid_reg;
    logic [tcc_pkg::X_W-1:0]  screen_x_reg;
    logic [tcc_pkg::X_W-1:0]  screen_x_next;
    logic [tcc_pkg::Y_W-1:0]  screen_y_reg;
    logic [tcc_pkg::Y_W-1:0]  screen_y_next;
    logic                     span_error_reg;

    tcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // prep stage: edge select, offsets, scale multiply
    assign x_lo = cal.enable ? cal.x_lo : tcc_pkg::DEF_X_LO;
    assign x_hi = cal.enable ? cal.x_hi : tcc_pkg::DEF_X_HI;
    assign y_lo = cal.enable ? cal.y_lo : tcc_pkg::DEF_Y_LO;
    assign y_hi = cal.enable ? cal.y_hi : tcc_pkg::DEF_Y_HI;

    always_comb
    begin
        prep_item_next.x   = tcc_pkg::axis_prep(raw_x, x_lo, x_hi,
                                                tcc_pkg::SIZE_W'(tcc_pkg::SCREEN_WIDTH));
        prep_item_next.y   = tcc_pkg::axis_prep(raw_y, y_lo, y_hi,
                                                tcc_pkg::SIZE_W'(tcc_pkg::SCREEN_HEIGHT));
        prep_item_next.err = (x_lo == x_hi) || (y_lo == y_hi);
    end

    assign prep_rdy     = !prep_valid_reg || lvl_rdy[0];
    assign sample_stall = !prep_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (prep_rdy)
            prep_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (prep_rdy && sample_valid)
            prep_item_reg <= prep_item_next;
    end

    assign lvl_valid[0] = prep_valid_reg;
    assign lvl_item[0]  = prep_item_reg;

    for (genvar k = 0; k < NS; k++)
    begin : g_div
        tcc_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lvl_valid[k]),
            .in_item   (lvl_item[k]),
            .in_rdy    (lvl_rdy[k]),
            .out_valid (lvl_valid[k+1]),
            .out_item  (lvl_item[k+1]),
            .out_rdy   (lvl_rdy[k+1])
        );
    end

    // clamp and output register
    assign lvl_rdy[NS] = !point_valid_reg || !point_stall;

    always_comb
    begin
        logic [tcc_pkg::QP+tcc_pkg::X_W-1:0] qx;
        logic [tcc_pkg::QP+tcc_pkg::Y_W-1:0] qy;
        qx = {{tcc_pkg::X_W{1'b0}}, lvl_item[NS].x.quo};
        qy = {{tcc_pkg::Y_W{1'b0}}, lvl_item[NS].y.quo};
        case (lvl_item[NS].x.sel)
            tcc_pkg::SEL_QUOT: screen_x_next = qx[tcc_pkg::X_W-1:0];
            tcc_pkg::SEL_MAX:  screen_x_next = tcc_pkg::X_MAX_CODE;
            default:           screen_x_next = '0;
        endcase
        case (lvl_item[NS].y.sel)
            tcc_pkg::SEL_QUOT: screen_y_next = qy[tcc_pkg::Y_W-1:0];
            tcc_pkg::SEL_MAX:  screen_y_next = tcc_pkg::Y_MAX_CODE;
            default:           screen_y_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_valid_reg <= 1'b0;
        else if (lvl_rdy[NS])
            point_valid_reg <= lvl_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        if (lvl_rdy[NS] && lvl_valid[NS])
        begin
            screen_x_reg   <= screen_x_next;
            screen_y_reg   <= screen_y_next;
            span_error_reg <= lvl_item[NS].err;
        end
    end

    assign point_valid = point_valid_reg;
    assign screen_x    = screen_x_reg;
    assign screen_y    = screen_y_reg;
    assign span_error  = span_error_reg;

    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && X_CHK |-> int'(screen_x) < tcc_pkg::SCREEN_WIDTH)
        else $error("screen_x beyond screen width");

    a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && Y_CHK |-> int'(screen_y) < tcc_pkg::SCREEN_HEIGHT)
        else $error("screen_y beyond screen height");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && span_error |-> screen_x == '0 || screen_y == '0)
        else $error("span error with both coordinates non-zero");

endmodule
